/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* rtl/core/hltp_pkg.sv */
// Package for the linear-probe hash table: codes, FSM states, hash constants.
// No dependencies.
`timescale 1ns / 1ps

package hltp_pkg;

    localparam int unsigned DEF_CAPACITY      = 64;
    localparam int unsigned DEF_MAX_KEY_BYTES = 8;
    localparam int unsigned DEF_VALUE_WIDTH   = 32;

    localparam logic [31:0] FNV_SEED  = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [6:0]  LOAD_LIMIT_RESET = 7'd48;

    typedef enum logic [1:0] {
        OP_GET = 2'd0,
        OP_SET = 2'd1,
        OP_DEL = 2'd2,
        OP_NOP = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_USED  = 2'd1,
        MARK_TOMB  = 2'd2,
        MARK_RSVD  = 2'd3
    } t_mark;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_FINISH
    } t_state;

endpackage

/* rtl/core/hltp_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module hltp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/core/hash_table_linear_probe.sv */
// Linear-probe hash table (FNV-1a home slot, tombstone delete, load limit).
// Uses hltp_pkg, hltp_ram and assert_macros.svh.
//
// Usage:
//   Request: raise start with i_opcode (get/set/delete), i_key_bytes,
//   i_key_length and i_write_value; the item is taken at an edge where start
//   is high and busy is low. busy stays high until the item is finished.
//   Result: o_result_valid pulses for one cycle with o_status/o_read_value.
//   The receiver cannot stall; a new item may be started in that same cycle.
//   Config: i_cfg_we writes i_cfg_wdata into the load limit; do it while idle.
// Steps per item: accept, then hashing (one byte-multiply per cycle over the key
//   bytes, then a step that loads the home slot), then for each slot probed a RAM
//   read state and a check state, then one finish/write-back state.
//   A nop opcode goes from accept straight to finish. The probe loop and the
//   single slot RAM set the time taken per item.
// Reset: synchronous, active low. After reset a clearing pass writes every
//   slot empty, one per cycle, with busy high; config writes are taken
//   during it.
`timescale 1ns / 1ps

module hash_table_linear_probe #(
    parameter int unsigned CAPACITY      = hltp_pkg::DEF_CAPACITY,
    parameter int unsigned MAX_KEY_BYTES = hltp_pkg::DEF_MAX_KEY_BYTES,
    parameter int unsigned VALUE_WIDTH   = hltp_pkg::DEF_VALUE_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [63:0] i_key_bytes,
    input  logic [3:0]  i_key_length,
    input  logic [31:0] i_write_value,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    output logic        o_result_valid,
    output logic [1:0]  o_status,
    output logic [31:0] o_read_value
);

    localparam int unsigned AW   = $clog2(CAPACITY);
    localparam int unsigned FW   = $clog2(CAPACITY + 1);
    localparam int unsigned CW   = (FW > 7) ? FW : 7;
    localparam int unsigned KW   = 8 * MAX_KEY_BYTES;
    localparam int unsigned VW   = VALUE_WIDTH;
    localparam int unsigned K_LO = VW;
    localparam int unsigned L_LO = VW + KW;
    localparam int unsigned M_LO = VW + KW + 4;
    localparam int unsigned EW   = VW + KW + 4 + 2;

    hltp_pkg::t_state r_state, n_state;

    logic [6:0]    r_load_limit;
    logic [FW-1:0] r_filled, n_filled;
    hltp_pkg::t_op r_op, n_op;
    logic [3:0]    r_len, n_len;
    logic [3:0]    r_cnt, n_cnt;
    logic [KW-1:0] r_key, n_key;
    logic [63:0]   r_kshift, n_kshift;
    logic [VW-1:0] r_wval, n_wval;
    logic [31:0]   r_hash, n_hash;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_step, n_step;
    logic          r_have_tomb, n_have_tomb;
    logic [AW-1:0] r_tomb_at, n_tomb_at;
    logic          r_hit_match, n_hit_match;
    logic          r_hit_empty, n_hit_empty;
    logic [VW-1:0] r_old_val, n_old_val;

    logic        r_out_stb, n_out_stb;
    logic [1:0]  r_out_status, n_out_status;
    logic [31:0] r_out_val, n_out_val;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;

    logic [3:0]    len_c;
    logic [63:0]   key_m;
    logic [63:0]   wval_ext;
    logic [63:0]   old_ext;
    logic [31:0]   mul_in;
    logic [CW-1:0] filled_cmp;
    logic [CW-1:0] limit_cmp;

    hltp_pkg::t_mark rd_mark;
    logic [3:0]      rd_len;
    logic [KW-1:0]   rd_key;
    logic [VW-1:0]   rd_val;

    hltp_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_mark = hltp_pkg::t_mark'(ram_rdata[M_LO +: 2]);
    assign rd_len  = ram_rdata[L_LO +: 4];
    assign rd_key  = ram_rdata[K_LO +: KW];
    assign rd_val  = ram_rdata[VW-1:0];

    always_comb begin
        len_c = (i_key_length > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : i_key_length;
        for (int b = 0; b < 8; b++) begin
            key_m[8*b +: 8] = (4'(b) < len_c) ? i_key_bytes[8*b +: 8] : 8'h00;
        end
    end

    assign wval_ext   = {32'b0, i_write_value};
    assign old_ext    = 64'(r_old_val);
    assign mul_in     = r_hash ^ {24'b0, r_kshift[7:0]};
    assign filled_cmp = CW'(r_filled);
    assign limit_cmp  = CW'(r_load_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= hltp_pkg::S_CLEAR;
            r_load_limit <= hltp_pkg::LOAD_LIMIT_RESET;
            r_filled     <= '0;
            r_idx        <= '0;
            r_out_stb    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_filled  <= n_filled;
            r_idx     <= n_idx;
            r_out_stb <= n_out_stb;
            if (i_cfg_we) begin
                r_load_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_len        <= n_len;
        r_cnt        <= n_cnt;
        r_key        <= n_key;
        r_kshift     <= n_kshift;
        r_wval       <= n_wval;
        r_hash       <= n_hash;
        r_step       <= n_step;
        r_have_tomb  <= n_have_tomb;
        r_tomb_at    <= n_tomb_at;
        r_hit_match  <= n_hit_match;
        r_hit_empty  <= n_hit_empty;
        r_old_val    <= n_old_val;
        r_out_status <= n_out_status;
        r_out_val    <= n_out_val;
    end

    always_comb begin
        n_state      = r_state;
        n_filled     = r_filled;
        n_op         = r_op;
        n_len        = r_len;
        n_cnt        = r_cnt;
        n_key        = r_key;
        n_kshift     = r_kshift;
        n_wval       = r_wval;
        n_hash       = r_hash;
        n_idx        = r_idx;
        n_step       = r_step;
        n_have_tomb  = r_have_tomb;
        n_tomb_at    = r_tomb_at;
        n_hit_match  = r_hit_match;
        n_hit_empty  = r_hit_empty;
        n_old_val    = r_old_val;
        n_out_stb    = 1'b0;
        n_out_status = r_out_status;
        n_out_val    = r_out_val;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = '0;

        unique case (r_state)
            hltp_pkg::S_CLEAR: begin
                // zero entry = empty mark
                ram_we = 1'b1;
                n_idx  = r_idx + 1'b1;
                if (r_idx == AW'(CAPACITY - 1)) begin
                    n_state = hltp_pkg::S_IDLE;
                end
            end
            hltp_pkg::S_IDLE: begin
                if (start) begin
                    n_op        = hltp_pkg::t_op'(i_opcode);
                    n_len       = len_c;
                    n_cnt       = '0;
                    n_key       = key_m[KW-1:0];
                    n_kshift    = key_m;
                    n_wval      = wval_ext[VW-1:0];
                    n_hash      = hltp_pkg::FNV_SEED;
                    n_have_tomb = 1'b0;
                    n_hit_match = 1'b0;
                    n_hit_empty = 1'b0;
                    n_state     = (hltp_pkg::t_op'(i_opcode) == hltp_pkg::OP_NOP)
                                  ? hltp_pkg::S_FINISH : hltp_pkg::S_HASH;
                end
            end
            hltp_pkg::S_HASH: begin
                if (r_cnt == r_len) begin
                    n_idx   = r_hash[AW-1:0];
                    n_step  = '0;
                    n_state = hltp_pkg::S_PROBE_RD;
                end else begin
                    n_hash   = 32'(mul_in * hltp_pkg::FNV_PRIME);
                    n_kshift = r_kshift >> 8;
                    n_cnt    = r_cnt + 1'b1;
                end
            end
            hltp_pkg::S_PROBE_RD: begin
                n_state = hltp_pkg::S_PROBE_CHK;
            end
            hltp_pkg::S_PROBE_CHK: begin
                if (rd_mark == hltp_pkg::MARK_EMPTY) begin
                    n_hit_empty = 1'b1;
                    n_state     = hltp_pkg::S_FINISH;
                end else if (rd_mark == hltp_pkg::MARK_TOMB || rd_len != r_len
                             || rd_key != r_key) begin
                    if (rd_mark == hltp_pkg::MARK_TOMB && !r_have_tomb) begin
                        n_have_tomb = 1'b1;
                        n_tomb_at   = r_idx;
                    end
                    if (r_step == AW'(CAPACITY - 1)) begin
                        n_state = hltp_pkg::S_FINISH;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_step  = r_step + 1'b1;
                        n_state = hltp_pkg::S_PROBE_RD;
                    end
                end else begin
                    n_hit_match = 1'b1;
                    n_old_val   = rd_val;
                    n_state     = hltp_pkg::S_FINISH;
                end
            end
            hltp_pkg::S_FINISH: begin
                n_out_stb    = 1'b1;
                n_out_status = hltp_pkg::ST_MISSING;
                n_out_val    = '0;
                n_state      = hltp_pkg::S_IDLE;
                case (r_op)
                    hltp_pkg::OP_GET: begin
                        if (r_hit_match) begin
                            n_out_status = hltp_pkg::ST_OK;
                            n_out_val    = old_ext[31:0];
                        end
                    end
                    hltp_pkg::OP_DEL: begin
                        if (r_hit_match) begin
                            ram_we       = 1'b1;
                            ram_wdata    = {hltp_pkg::MARK_TOMB, 4'b0, {KW{1'b0}}, r_old_val};
                            n_out_status = hltp_pkg::ST_OK;
                        end
                    end
                    hltp_pkg::OP_SET: begin
                        ram_wdata = {hltp_pkg::MARK_USED, r_len, r_key, r_wval};
                        if (r_hit_match) begin
                            ram_we       = 1'b1;
                            n_out_status = hltp_pkg::ST_OK;
                        end else if (filled_cmp >= limit_cmp) begin
                            n_out_status = hltp_pkg::ST_FULL;
                        end else if (r_have_tomb) begin
                            ram_we       = 1'b1;
                            ram_waddr    = r_tomb_at;
                            n_out_status = hltp_pkg::ST_OK;
                        end else if (r_hit_empty) begin
                            ram_we       = 1'b1;
                            n_filled     = r_filled + 1'b1;
                            n_out_status = hltp_pkg::ST_OK;
                        end else begin
                            n_out_status = hltp_pkg::ST_FULL;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = hltp_pkg::S_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != hltp_pkg::S_IDLE);
    assign o_result_valid = r_out_stb;
    assign o_status       = r_out_status;
    assign o_read_value   = r_out_val;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_accept_goes_busy, i_clk, i_rst_n, start && !busy, busy)
    `ASSERT_NEXT(a_result_after_finish, i_clk, i_rst_n, r_state == hltp_pkg::S_FINISH, o_result_valid)
    `ASSERT_IMPL(a_fail_no_value, i_clk, i_rst_n, o_result_valid && o_status != hltp_pkg::ST_OK, o_read_value == 32'd0)
    `ASSERT_IMPL(a_filled_bound, i_clk, i_rst_n, 1'b1, CW'(r_filled) <= CW'(CAPACITY))

endmodule
